// ===== sv/text_whitespace_punct_normalizer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the text normalizer
// Clocked property checks that simulation enables and synthesis drops.
// ----------------------------------------------------------------------------
`ifndef TEXT_WHITESPACE_PUNCT_NORMALIZER_ASSERT_SVH
`define TEXT_WHITESPACE_PUNCT_NORMALIZER_ASSERT_SVH
`ifndef SYNTHESIS
// Checked at each rising edge while reset is released.
`define TWPN_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at each rising edge, reset included.
`define TWPN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TWPN_ASSERT(lbl, clk, rst_n, prop, msg)
`define TWPN_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== sv/twpn_pkg.sv =====
// ----------------------------------------------------------------------------
// Text normalizer package
// Character codes, limits and the per-byte output list shared by all parts.
// ----------------------------------------------------------------------------
`default_nettype none

package twpn_pkg;

    // Characters that the normalizer treats specially.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_EXCL  = 8'h21;
    localparam logic [7:0] CH_QUES  = 8'h3F;

    // Most output bytes that one input byte can cause.
    localparam int MAX_RES = 6;
    localparam int CNT_W   = 3;
    typedef logic [CNT_W-1:0] t_cnt;
    localparam t_cnt MAX_CNT = t_cnt'(MAX_RES);

    // Dot run handling: exactly three dots form an ellipsis, runs saturate at four.
    localparam logic [2:0] DOT_ELLIPSIS = 3'd3;
    localparam logic [2:0] DOT_SAT      = 3'd4;

    // Newline runs saturate at two.
    localparam logic [1:0] NL_SAT = 2'd2;

    // Default depth of the queue between front and back.
    localparam int FIFO_DEPTH = 4;

    // Output list for one accepted input byte.
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;    // bytes in order, entry 0 first
        t_cnt                    cnt;      // number of results, 1 to MAX_RES
        logic                    has_byte; // 0 for a bare end marker
        logic                    last;     // list closes the text
    } t_item;

endpackage

`default_nettype wire

// ===== sv/twpn_front.sv =====
// ----------------------------------------------------------------------------
// Text normalizer front end
// Runs both normalizing stages on one accepted byte and builds its output list.
// ----------------------------------------------------------------------------
`default_nettype none

module twpn_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire logic [7:0]     i_text_byte,
    input  wire logic           i_last_of_text,
    input  wire logic           i_q_full,
    output logic                o_q_push,
    output twpn_pkg::t_item     o_q_data
);

`include "text_whitespace_punct_normalizer_assert.svh"

    // Working state of stage two while one list is built.
    typedef struct packed {
        logic [2:0]                        held;
        logic [7:0]                        prev;
        twpn_pkg::t_cnt                    cnt;
        logic [twpn_pkg::MAX_RES-1:0][7:0] bytes;
    } t_s2;

    // Append one byte to the list.
    function automatic t_s2 f_append(t_s2 s, logic [7:0] b);
        t_s2 r;
        r = s;
        if (r.cnt < twpn_pkg::MAX_CNT) begin
            r.bytes[r.cnt] = b;
            r.cnt          = r.cnt + 3'd1;
        end
        return r;
    endfunction

    // Release held dots: an ellipsis for exactly three, one dot otherwise.
    function automatic t_s2 f_flush(t_s2 s);
        t_s2 r;
        r = s;
        if (r.held == twpn_pkg::DOT_ELLIPSIS) begin
            r = f_append(r, twpn_pkg::CH_DOT);
            r = f_append(r, twpn_pkg::CH_DOT);
            r = f_append(r, twpn_pkg::CH_DOT);
        end else if (r.held != 3'd0) begin
            r = f_append(r, twpn_pkg::CH_DOT);
        end
        r.held = 3'd0;
        return r;
    endfunction

    // Punctuation stage for one byte.
    function automatic t_s2 f_stage_two(t_s2 s, logic [7:0] b);
        t_s2 r;
        r = s;
        if (b == twpn_pkg::CH_DOT) begin
            if (r.held < twpn_pkg::DOT_SAT) begin
                r.held = r.held + 3'd1;
            end
        end else begin
            r = f_flush(r);
            if (!((b == twpn_pkg::CH_EXCL || b == twpn_pkg::CH_QUES) && r.prev == b)) begin
                r = f_append(r, b);
            end
        end
        r.prev = b;
        return r;
    endfunction

    logic       r_started;
    logic [1:0] r_nl;
    logic       r_space;
    logic [7:0] r_prev;
    logic [2:0] r_held;

    logic       n_started;
    logic [1:0] n_nl;
    logic       n_space;
    t_s2        n_s2;
    logic       skip;
    logic       is_ws;
    logic       accept;
    logic       marker;

    assign full   = i_q_full;
    assign accept = push && !i_q_full;

    // Whitespace stage, then punctuation stage, then the end-of-text flush.
    always_comb begin
        n_started = r_started;
        n_nl      = r_nl;
        n_space   = r_space;
        n_s2      = '{held: r_held, prev: r_prev, cnt: '0, bytes: '0};
        skip      = 1'b0;
        marker    = 1'b0;
        is_ws     = (i_text_byte == twpn_pkg::CH_SPACE) || (i_text_byte == twpn_pkg::CH_TAB)
                 || (i_text_byte == twpn_pkg::CH_LF);

        if (!r_started) begin
            if (is_ws) begin
                skip = 1'b1;
            end else begin
                n_started = 1'b1;
            end
        end

        if (!skip) begin
            if (i_text_byte == twpn_pkg::CH_LF) begin
                if (n_nl < twpn_pkg::NL_SAT) begin
                    n_nl = n_nl + 2'd1;
                end
                n_space = 1'b0;
            end else if (i_text_byte == twpn_pkg::CH_SPACE
                      || i_text_byte == twpn_pkg::CH_TAB) begin
                if (n_nl == 2'd0) begin
                    n_space = 1'b1;
                end
            end else begin
                if (n_nl != 2'd0) begin
                    n_s2 = f_stage_two(n_s2, twpn_pkg::CH_LF);
                    if (n_nl >= twpn_pkg::NL_SAT) begin
                        n_s2 = f_stage_two(n_s2, twpn_pkg::CH_LF);
                    end
                    n_nl = 2'd0;
                end else if (n_space) begin
                    n_s2 = f_stage_two(n_s2, twpn_pkg::CH_SPACE);
                end
                n_space = 1'b0;
                n_s2    = f_stage_two(n_s2, i_text_byte);
            end
        end

        if (i_last_of_text) begin
            n_s2 = f_flush(n_s2);
            if (n_s2.cnt == '0) begin
                marker   = 1'b1;
                n_s2.cnt = twpn_pkg::t_cnt'(1);
            end
        end
    end

    // List handed to the queue; an empty list is dropped.
    assign o_q_push          = accept && (n_s2.cnt != '0);
    assign o_q_data.bytes    = n_s2.bytes;
    assign o_q_data.cnt      = n_s2.cnt;
    assign o_q_data.has_byte = !marker;
    assign o_q_data.last     = i_last_of_text;

    // Stage state advances per transaction and clears after the end of text.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_nl      <= 2'd0;
            r_space   <= 1'b0;
            r_prev    <= 8'd0;
            r_held    <= 3'd0;
        end else if (accept) begin
            if (i_last_of_text) begin
                r_started <= 1'b0;
                r_nl      <= 2'd0;
                r_space   <= 1'b0;
                r_prev    <= 8'd0;
                r_held    <= 3'd0;
            end else begin
                r_started <= n_started;
                r_nl      <= n_nl;
                r_space   <= n_space;
                r_prev    <= n_s2.prev;
                r_held    <= n_s2.held;
            end
        end
    end

    `TWPN_ASSERT(a_held_range, i_clk, i_rst_n, r_held <= twpn_pkg::DOT_SAT, "dot count beyond saturation")
    `TWPN_ASSERT(a_nl_range, i_clk, i_rst_n, r_nl <= twpn_pkg::NL_SAT, "newline count beyond saturation")

endmodule

`default_nettype wire

// ===== sv/twpn_fifo.sv =====
// ----------------------------------------------------------------------------
// Text normalizer list queue
// Small register queue of output lists between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module twpn_fifo #(
    parameter int DEPTH = twpn_pkg::FIFO_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire twpn_pkg::t_item i_data,
    output logic                 o_full,
    input  wire logic            i_pop,
    output twpn_pkg::t_item      o_data,
    output logic                 o_empty
);

`include "text_whitespace_punct_normalizer_assert.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    twpn_pkg::t_item  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == DEPTH_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `TWPN_ASSERT(a_fill_bound, i_clk, i_rst_n, r_count <= DEPTH_CNT, "queue fill beyond depth")

endmodule

`default_nettype wire

// ===== sv/twpn_back.sv =====
// ----------------------------------------------------------------------------
// Text normalizer back end
// Holds one output list and hands out its bytes, one per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module twpn_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire twpn_pkg::t_item i_q_data,
    input  wire logic            i_q_empty,
    output logic                 o_q_pop,
    output logic                 empty,
    input  wire logic            pop,
    output logic [7:0]           o_out_byte,
    output logic                 o_has_byte,
    output logic                 o_last_of_run,
    output logic                 o_end_of_text
);

`include "text_whitespace_punct_normalizer_assert.svh"

    twpn_pkg::t_item r_cur;
    logic            r_valid;
    twpn_pkg::t_cnt  r_idx;
    logic            at_end;
    logic            take;
    logic            load;

    assign at_end = (r_idx == r_cur.cnt - twpn_pkg::t_cnt'(1));
    assign take   = pop && r_valid;
    assign load   = !i_q_empty && (!r_valid || (take && at_end));
    assign o_q_pop = load;

    // Result ports come straight from the held list.
    assign empty         = !r_valid;
    assign o_out_byte    = r_cur.bytes[r_idx];
    assign o_has_byte    = r_cur.has_byte;
    assign o_last_of_run = at_end;
    assign o_end_of_text = at_end && r_cur.last;

    // Step through the list; the next list loads as the last byte leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (take) begin
            if (at_end) begin
                r_valid <= 1'b0;
                r_idx   <= '0;
            end else begin
                r_idx <= r_idx + twpn_pkg::t_cnt'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= i_q_data;
        end
    end

    `TWPN_ASSERT(a_idx_in_list, i_clk, i_rst_n, r_valid |-> (r_idx < r_cur.cnt), "index beyond list length")
    `TWPN_ASSERT(a_stall_holds, i_clk, i_rst_n, (r_valid && !pop) |=> (r_valid && $stable(r_idx)), "result changed while stalled")

endmodule

`default_nettype wire

// ===== sv/text_whitespace_punct_normalizer.sv =====
// ----------------------------------------------------------------------------
// Text whitespace and punctuation normalizer
// Collapses whitespace and repeated punctuation in a byte stream.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Payload
//  input     in         push / full         i_text_byte, i_last_of_text
//  result    out        pop / empty         o_out_byte, o_has_byte,
//                                           o_last_of_run, o_end_of_text
//
//  One input byte is taken per cycle while the list queue has room.
//  Each input byte causes zero to six results; the back end hands out one a cycle
//  while pop is asserted, so a byte with n results takes n pops on the result side.
//  A byte that causes no result and is not the end of text only updates state.
//  Reset is synchronous and clears the stage state, the queue and the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module text_whitespace_punct_normalizer #(
    parameter int FIFO_DEPTH = twpn_pkg::FIFO_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_last_of_text,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_out_byte,
    output logic            o_has_byte,
    output logic            o_last_of_run,
    output logic            o_end_of_text
);

    twpn_pkg::t_item q_in;
    twpn_pkg::t_item q_out;
    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;

    // Both stages on the incoming byte.
    twpn_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_text_byte    (i_text_byte),
        .i_last_of_text (i_last_of_text),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_data       (q_in)
    );

    // Output lists waiting for the back end.
    twpn_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    // Byte-by-byte result delivery.
    twpn_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_data      (q_out),
        .i_q_empty     (q_empty),
        .o_q_pop       (q_pop),
        .empty         (empty),
        .pop           (pop),
        .o_out_byte    (o_out_byte),
        .o_has_byte    (o_has_byte),
        .o_last_of_run (o_last_of_run),
        .o_end_of_text (o_end_of_text)
    );

endmodule

`default_nettype wire
